FILE: rtl/core/qec_pkg.sv
// ----------------------------------------------------------------------------
// qec_pkg: shared definitions for the quad8 element connectivity unit
// Widths, configuration register indexes and the structs that travel
// between the divider cells, the node calculator and the top level.
// ----------------------------------------------------------------------------
package qec_pkg;

  localparam int MAX_SIDE   = 1024;
  localparam int SIDE_W     = 11;
  localparam int IDX_W      = 20;
  localparam int NODE_W     = 22;
  localparam int COL_W      = $clog2(MAX_SIDE);
  localparam int CFG_ADDR_W = 2;
  localparam int DIV_CELLS  = IDX_W;
  localparam int NODE_CNT   = 8;

  // Positions of the node numbers inside a result.
  localparam int N_CORNER_BL = 0;
  localparam int N_CORNER_BR = 1;
  localparam int N_CORNER_TR = 2;
  localparam int N_CORNER_TL = 3;
  localparam int N_MID_B     = 4;
  localparam int N_MID_R     = 5;
  localparam int N_MID_T     = 6;
  localparam int N_MID_L     = 7;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GRID_COLUMNS  = 2'd0,
    REG_GRID_ROWS     = 2'd1,
    REG_PERIODIC_MODE = 2'd2
  } cfg_reg_t;

  // One item on its way down the divider chain.
  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  dividend;
    logic [SIDE_W-1:0] rem;
    logic [IDX_W-1:0]  quot;
  } div_tok_t;

  // One finished result.
  typedef struct packed {
    logic                             valid;
    logic                             index_error;
    logic [NODE_CNT-1:0][NODE_W-1:0]  nodes;
  } node_res_t;

  // A side length of zero is used as one, anything above the limit as the limit.
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (v > SIDE_W'(MAX_SIDE)) begin
      r = SIDE_W'(MAX_SIDE);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/qec_div_cell.sv
// ----------------------------------------------------------------------------
// qec_div_cell: one restoring division cell
// Takes the next dividend bit into the partial remainder, subtracts the
// divisor when it fits and shifts one quotient bit in.
// ----------------------------------------------------------------------------
module qec_div_cell
  import qec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [SIDE_W-1:0] divisor,
  input  div_tok_t          tok_in,
  output div_tok_t          tok_out
);

  logic              valid_r;
  logic [IDX_W-1:0]  dividend_r;
  logic [SIDE_W-1:0] rem_r;
  logic [IDX_W-1:0]  quot_r;

  logic [IDX_W-1:0]  dividend_nxt;
  logic [SIDE_W-1:0] rem_nxt;
  logic [IDX_W-1:0]  quot_nxt;
  logic [SIDE_W:0]   trial;
  logic [SIDE_W:0]   diff;
  logic              take;

  always_comb begin
    trial        = {tok_in.rem, tok_in.dividend[IDX_W-1]};
    diff         = trial - {1'b0, divisor};
    take         = (trial >= {1'b0, divisor});
    rem_nxt      = take ? diff[SIDE_W-1:0] : trial[SIDE_W-1:0];
    dividend_nxt = {tok_in.dividend[IDX_W-2:0], 1'b0};
    quot_nxt     = {tok_in.quot[IDX_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dividend_r <= dividend_nxt;
      rem_r      <= rem_nxt;
      quot_r     <= quot_nxt;
    end
  end

  assign tok_out = '{valid: valid_r, dividend: dividend_r, rem: rem_r, quot: quot_r};

endmodule

FILE: rtl/core/qec_node_calc.sv
// ----------------------------------------------------------------------------
// qec_node_calc: node numbering from column and row
// Three stages: range check and products, row offsets and block bases,
// then the final sums with zeroing of out-of-range items.
// ----------------------------------------------------------------------------
module qec_node_calc
  import qec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [SIDE_W-1:0] nx,
  input  logic [SIDE_W-1:0] ny,
  input  logic              periodic,
  input  div_tok_t          tok_in,
  output node_res_t         res
);

  // Stage 1
  logic              p1_valid_r, p1_err_r, p1_wrap_r;
  logic [SIDE_W-1:0] p1_i_r, p1_i1_r, p1_w_r;
  logic [NODE_W-1:0] p1_jw_r, p1_jnx_r, p1_prod_a_r, p1_prod_b_r;

  logic              p1_err_nxt, p1_wrap_nxt;
  logic [SIDE_W-1:0] p1_i1_nxt, p1_w_nxt, i_inc, j_inc;
  logic [COL_W-1:0]  j;
  logic [NODE_W-1:0] p1_jw_nxt, p1_jnx_nxt, p1_prod_a_nxt, p1_prod_b_nxt, nxny;

  always_comb begin
    j             = tok_in.quot[COL_W-1:0];
    p1_err_nxt    = (tok_in.quot >= IDX_W'(ny));
    i_inc         = tok_in.rem + SIDE_W'(1);
    j_inc         = SIDE_W'(j) + SIDE_W'(1);
    p1_i1_nxt     = (periodic && (i_inc == nx)) ? '0 : i_inc;
    p1_wrap_nxt   = periodic && (j_inc == ny);
    p1_w_nxt      = periodic ? nx : nx + SIDE_W'(1);
    p1_jw_nxt     = NODE_W'(j) * NODE_W'(p1_w_nxt);
    p1_jnx_nxt    = NODE_W'(j) * NODE_W'(nx);
    nxny          = NODE_W'(nx) * NODE_W'(ny);
    p1_prod_a_nxt = periodic ? nxny
                             : NODE_W'(nx + SIDE_W'(1)) * NODE_W'(ny + SIDE_W'(1));
    p1_prod_b_nxt = periodic ? nxny : NODE_W'(nx) * NODE_W'(ny + SIDE_W'(1));
  end

  // Stage 2
  logic              p2_valid_r, p2_err_r;
  logic [SIDE_W-1:0] p2_i_r, p2_i1_r;
  logic [NODE_W-1:0] p2_jw_r, p2_jnx_r, p2_j1w_r, p2_j1nx_r, p2_xb_r, p2_yb_r;
  logic [NODE_W-1:0] p2_j1w_nxt, p2_j1nx_nxt, p2_yb_nxt;

  always_comb begin
    p2_j1w_nxt  = p1_wrap_r ? '0 : p1_jw_r + NODE_W'(p1_w_r);
    p2_j1nx_nxt = p1_wrap_r ? '0 : p1_jnx_r + NODE_W'(nx);
    p2_yb_nxt   = p1_prod_a_r + p1_prod_b_r;
  end

  // Stage 3
  logic                            p3_valid_r, p3_err_r;
  logic [NODE_CNT-1:0][NODE_W-1:0] p3_nodes_r, p3_nodes_nxt;
  logic [NODE_W-1:0]               i_ext, i1_ext;

  always_comb begin
    i_ext  = NODE_W'(p2_i_r);
    i1_ext = NODE_W'(p2_i1_r);
    p3_nodes_nxt[N_CORNER_BL] = p2_jw_r + i_ext;
    p3_nodes_nxt[N_CORNER_BR] = p2_jw_r + i1_ext;
    p3_nodes_nxt[N_CORNER_TR] = p2_j1w_r + i1_ext;
    p3_nodes_nxt[N_CORNER_TL] = p2_j1w_r + i_ext;
    p3_nodes_nxt[N_MID_B]     = p2_xb_r + p2_jnx_r + i_ext;
    p3_nodes_nxt[N_MID_R]     = p2_yb_r + p2_jw_r + i1_ext;
    p3_nodes_nxt[N_MID_T]     = p2_xb_r + p2_j1nx_r + i_ext;
    p3_nodes_nxt[N_MID_L]     = p2_yb_r + p2_jw_r + i_ext;
    if (p2_err_r) begin
      p3_nodes_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
    end else if (adv) begin
      p1_valid_r <= tok_in.valid;
      p2_valid_r <= p1_valid_r;
      p3_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_err_r    <= p1_err_nxt;
      p1_wrap_r   <= p1_wrap_nxt;
      p1_i_r      <= tok_in.rem;
      p1_i1_r     <= p1_i1_nxt;
      p1_w_r      <= p1_w_nxt;
      p1_jw_r     <= p1_jw_nxt;
      p1_jnx_r    <= p1_jnx_nxt;
      p1_prod_a_r <= p1_prod_a_nxt;
      p1_prod_b_r <= p1_prod_b_nxt;

      p2_err_r    <= p1_err_r;
      p2_i_r      <= p1_i_r;
      p2_i1_r     <= p1_i1_r;
      p2_jw_r     <= p1_jw_r;
      p2_jnx_r    <= p1_jnx_r;
      p2_j1w_r    <= p2_j1w_nxt;
      p2_j1nx_r   <= p2_j1nx_nxt;
      p2_xb_r     <= p1_prod_a_r;
      p2_yb_r     <= p2_yb_nxt;

      p3_err_r    <= p2_err_r;
      p3_nodes_r  <= p3_nodes_nxt;
    end
  end

  assign res = '{valid: p3_valid_r, index_error: p3_err_r, nodes: p3_nodes_r};

endmodule

FILE: rtl/core/quad8_element_connectivity_unit.sv
// ----------------------------------------------------------------------------
// quad8_element_connectivity_unit: 8-node quad element connectivity
// Maps an element index on a structured grid to its four corner and four
// mid-side node numbers, in plain or periodic numbering.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   -------   ------------------   ------------------------------------------
//   input     in_valid / in_stall  in_element_index (20 bits)
//   result    out_valid/out_stall  eight 22-bit node numbers, out_index_error
//   config    cfg_write_en         cfg_index (2 bits), cfg_data (11 bits)
//
// One item is taken per cycle while in_stall is low; the edge that accepts
// an item loads it into the first of 20 divider cells, and 3 node stages and
// the output register follow before its result shows on the output.
// The divider chain resolves one quotient bit per cell.
// rst_n is synchronous and active low; it empties the pipeline and sets the
// grid to one by one elements in plain numbering.
// The whole pipeline holds only when a result is waiting in the output
// register, the far side stalls, and the next result is already at the tail;
// bubbles are squeezed out otherwise.
//
// The element index is divided by the column count in a chain of restoring
// division cells. The remainder is the column and the quotient the row. An
// index is out of range exactly when the row reaches the row count, so no
// product of the two sides is needed for the range check. The node stages
// then form the row offsets and the base of each node block with small
// multipliers and finish with the sums. Side lengths are clamped to the
// range one to MAX_SIDE before use.
// ----------------------------------------------------------------------------
module quad8_element_connectivity_unit
  import qec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_write_en,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [SIDE_W-1:0]     cfg_data,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [IDX_W-1:0]      in_element_index,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [NODE_W-1:0]     out_corner_bottom_left,
  output logic [NODE_W-1:0]     out_corner_bottom_right,
  output logic [NODE_W-1:0]     out_corner_top_right,
  output logic [NODE_W-1:0]     out_corner_top_left,
  output logic [NODE_W-1:0]     out_mid_bottom,
  output logic [NODE_W-1:0]     out_mid_right,
  output logic [NODE_W-1:0]     out_mid_top,
  output logic [NODE_W-1:0]     out_mid_left,
  output logic                  out_index_error
);

  // Configuration registers. The user must issue writes only while the block is idle,
  // so every item in flight sees the same grid; the block itself does not enforce this.
  logic [SIDE_W-1:0] grid_columns_r;
  logic [SIDE_W-1:0] grid_rows_r;
  logic              periodic_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_columns_r  <= SIDE_W'(1);
      grid_rows_r     <= SIDE_W'(1);
      periodic_mode_r <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_COLUMNS:  grid_columns_r  <= cfg_data;
        REG_GRID_ROWS:     grid_rows_r     <= cfg_data;
        REG_PERIODIC_MODE: periodic_mode_r <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  logic [SIDE_W-1:0] nx;
  logic [SIDE_W-1:0] ny;

  assign nx = clamp_side(grid_columns_r);
  assign ny = clamp_side(grid_rows_r);

  // Global advance. Everything moves unless a finished result would have
  // nowhere to go.
  node_res_t res;
  logic      out_valid_r;
  logic      adv;
  logic      out_load;

  assign adv      = !(out_valid_r && out_stall && res.valid);
  assign in_stall = !adv;
  assign out_load = !out_valid_r || !out_stall;

  // Divider chain: each cell resolves one quotient bit, most significant first.
  div_tok_t tok [DIV_CELLS+1];

  assign tok[0] = '{valid: in_valid, dividend: in_element_index, rem: '0, quot: '0};

  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
    qec_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .divisor (nx),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  qec_node_calc u_node_calc (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .nx       (nx),
    .ny       (ny),
    .periodic (periodic_mode_r),
    .tok_in   (tok[DIV_CELLS]),
    .res      (res)
  );

  // Output register. It takes a new result (or a bubble) whenever it is
  // empty or its current result is being taken.
  logic [NODE_CNT-1:0][NODE_W-1:0] out_nodes_r;
  logic                            out_error_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_nodes_r <= res.nodes;
      out_error_r <= res.index_error;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_index_error         = out_error_r;
  assign out_corner_bottom_left  = out_nodes_r[N_CORNER_BL];
  assign out_corner_bottom_right = out_nodes_r[N_CORNER_BR];
  assign out_corner_top_right    = out_nodes_r[N_CORNER_TR];
  assign out_corner_top_left     = out_nodes_r[N_CORNER_TL];
  assign out_mid_bottom          = out_nodes_r[N_MID_B];
  assign out_mid_right           = out_nodes_r[N_MID_R];
  assign out_mid_top             = out_nodes_r[N_MID_T];
  assign out_mid_left            = out_nodes_r[N_MID_L];

  // The input side is held back only by a blocked output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled while the output register can move");

  // A result held at the pipeline tail is still there in the next cycle.
  a_tail_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && res.valid) |=> res.valid)
    else $error("result at the pipeline tail was dropped");

  // An out-of-range element carries no node numbers.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_r) |-> (out_nodes_r == '0))
    else $error("out-of-range result has nonzero node numbers");

  // A result that is waiting does not lose its valid or change its node numbers.
  a_out_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_nodes_r)))
    else $error("stalled result changed");

endmodule

FILE: verif/tb_quad8_element_connectivity_unit.sv
// ----------------------------------------------------------------------------
// tb_quad8_element_connectivity_unit: self-checking bench for the quad8 unit
// Streams element indexes through the unit under several grid settings and
// checks every node number and the error flag against a predictor kept here.
// ----------------------------------------------------------------------------
module tb_quad8_element_connectivity_unit
  import qec_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // The configuration port is two bits wide, so one index has no register
  // behind it. Writes to it must leave the grid alone.
  localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED = 2'd3;

  // Generous bound on the whole run; the slowest correct run needs far less.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_LIMIT  = 10;
  localparam int TAIL_CYCLES   = 40;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 55;

  // One expected result: the eight node numbers and the range flag.
  typedef struct packed {
    logic                            index_error;
    logic [NODE_CNT-1:0][NODE_W-1:0] nodes;
  } connectivity_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_write_en;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [SIDE_W-1:0]     cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [IDX_W-1:0]      in_element_index;
  logic                  out_valid;
  logic                  out_stall;
  logic [NODE_W-1:0]     out_corner_bottom_left;
  logic [NODE_W-1:0]     out_corner_bottom_right;
  logic [NODE_W-1:0]     out_corner_top_right;
  logic [NODE_W-1:0]     out_corner_top_left;
  logic [NODE_W-1:0]     out_mid_bottom;
  logic [NODE_W-1:0]     out_mid_right;
  logic [NODE_W-1:0]     out_mid_top;
  logic [NODE_W-1:0]     out_mid_left;
  logic                  out_index_error;

  // Our own copy of the three grid registers, updated as they are written.
  logic [SIDE_W-1:0] mirror_columns;
  logic [SIDE_W-1:0] mirror_rows;
  logic              mirror_periodic;

  // Results still owed by the unit, oldest first.
  connectivity_t expected_connectivity[$];

  int mismatch_count;
  int cycle_count;

  // Chance, in percent, that the sender skips a cycle or the receiver stalls.
  int send_idle_pct;
  int recv_idle_pct;
  // Cycles of forced back-pressure still to go; the receiver counts it down.
  int stall_hold_left;

  string node_label [NODE_CNT] = '{
    "corner_bottom_left", "corner_bottom_right", "corner_top_right",
    "corner_top_left", "mid_bottom", "mid_right", "mid_top", "mid_left"
  };

  quad8_element_connectivity_unit dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_write_en            (cfg_write_en),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_element_index        (in_element_index),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_corner_bottom_left  (out_corner_bottom_left),
    .out_corner_bottom_right (out_corner_bottom_right),
    .out_corner_top_right    (out_corner_top_right),
    .out_corner_top_left     (out_corner_top_left),
    .out_mid_bottom          (out_mid_bottom),
    .out_mid_right           (out_mid_right),
    .out_mid_top             (out_mid_top),
    .out_mid_left            (out_mid_left),
    .out_index_error         (out_index_error)
  );

  // 12 ns clock period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The run must finish well inside this many cycles; a hang ends it here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_connectivity.size());
      $display("tb_quad8_element_connectivity_unit: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // A side of zero counts as one element, anything past the limit as the limit.
  function automatic longint unsigned usable_side(input logic [SIDE_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > SIDE_W'(MAX_SIDE)) return MAX_SIDE;
    return raw;
  endfunction

  // Node numbers of one element under the current grid registers. In plain
  // numbering corner and y-midpoint rows hold nx+1 nodes and x-midpoint rows
  // nx; the three blocks follow one another. In periodic numbering every row
  // holds nx nodes, the +1 neighbors wrap to zero, and each block has nx*ny
  // entries.
  function automatic connectivity_t element_connectivity(input logic [IDX_W-1:0] idx);
    connectivity_t   r;
    longint unsigned nx, ny, col, row, col_next, row_next;
    longint unsigned corner_stride, ymid_stride, xmid_base, ymid_base;
    nx = usable_side(mirror_columns);
    ny = usable_side(mirror_rows);
    r.nodes = '0;
    r.index_error = 1'b0;
    if (longint'(idx) >= nx * ny) begin
      r.index_error = 1'b1;
      return r;
    end
    col = idx % nx;
    row = idx / nx;
    if (mirror_periodic) begin
      col_next      = (col + 1 == nx) ? 0 : col + 1;
      row_next      = (row + 1 == ny) ? 0 : row + 1;
      corner_stride = nx;
      ymid_stride   = nx;
      xmid_base     = nx * ny;
      ymid_base     = 2 * nx * ny;
    end else begin
      col_next      = col + 1;
      row_next      = row + 1;
      corner_stride = nx + 1;
      ymid_stride   = nx + 1;
      xmid_base     = (nx + 1) * (ny + 1);
      ymid_base     = xmid_base + nx * (ny + 1);
    end
    r.nodes[N_CORNER_BL] = NODE_W'(row * corner_stride + col);
    r.nodes[N_CORNER_BR] = NODE_W'(row * corner_stride + col_next);
    r.nodes[N_CORNER_TR] = NODE_W'(row_next * corner_stride + col_next);
    r.nodes[N_CORNER_TL] = NODE_W'(row_next * corner_stride + col);
    r.nodes[N_MID_B]     = NODE_W'(xmid_base + row * nx + col);
    r.nodes[N_MID_R]     = NODE_W'(ymid_base + row * ymid_stride + col_next);
    r.nodes[N_MID_T]     = NODE_W'(xmid_base + row_next * nx + col);
    r.nodes[N_MID_L]     = NODE_W'(ymid_base + row * ymid_stride + col);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic compare_field(input string field, input logic [NODE_W-1:0] want,
                               input logic [NODE_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("Mismatch at cycle %0d on %s: expected %0d, got %0d",
                 cycle_count, field, want, got);
      end
    end
  endtask

  // Every result the unit hands over is held against the oldest prediction.
  always @(posedge clk) begin
    connectivity_t want;
    logic [NODE_CNT-1:0][NODE_W-1:0] got;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_connectivity.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("Unexpected result at cycle %0d: nothing was pending", cycle_count);
        end
      end else begin
        want = expected_connectivity.pop_front();
        got[N_CORNER_BL] = out_corner_bottom_left;
        got[N_CORNER_BR] = out_corner_bottom_right;
        got[N_CORNER_TR] = out_corner_top_right;
        got[N_CORNER_TL] = out_corner_top_left;
        got[N_MID_B]     = out_mid_bottom;
        got[N_MID_R]     = out_mid_right;
        got[N_MID_T]     = out_mid_top;
        got[N_MID_L]     = out_mid_left;
        for (int k = 0; k < NODE_CNT; k++) begin
          compare_field(node_label[k], want.nodes[k], got[k]);
        end
        compare_field("index_error", NODE_W'(want.index_error), NODE_W'(out_index_error));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, or a long forced hold-off when one is requested.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (stall_hold_left > 0) begin
        out_stall <= 1'b1;
        stall_hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared driving tasks
  // --------------------------------------------------------------------------

  // Offers one item, after a random number of idle cycles, and records its
  // prediction at the edge where the unit takes it. Valid stays high after
  // acceptance; the next call or drain_results decides what it does next.
  task automatic send_element(input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_element_index <= idx;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_connectivity.push_back(element_connectivity(idx));
  endtask

  // Stops offering items and waits until every result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_connectivity.size() != 0) @(posedge clk);
  endtask

  // Register writes are only issued while the unit is empty.
  task automatic write_register(input logic [CFG_ADDR_W-1:0] which,
                                input logic [SIDE_W-1:0] value);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= which;
    cfg_data     <= value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    case (which)
      REG_GRID_COLUMNS:  mirror_columns  = value;
      REG_GRID_ROWS:     mirror_rows     = value;
      REG_PERIODIC_MODE: mirror_periodic = value[0];
      default: ;
    endcase
  endtask

  task automatic set_grid(input logic [SIDE_W-1:0] columns, input logic [SIDE_W-1:0] rows,
                          input logic [SIDE_W-1:0] periodic);
    write_register(REG_GRID_COLUMNS, columns);
    write_register(REG_GRID_ROWS, rows);
    write_register(REG_PERIODIC_MODE, periodic);
  endtask

  // Raw side value for a random phase: mostly small grids, with zero, one,
  // the limit and over-limit values mixed in so the clamp is exercised.
  function automatic logic [SIDE_W-1:0] pick_side();
    case ($urandom_range(9))
      0:       return '0;
      1:       return SIDE_W'($urandom_range(2047, MAX_SIDE + 1));
      2:       return SIDE_W'(MAX_SIDE);
      3:       return SIDE_W'(1);
      4, 5:    return SIDE_W'($urandom_range(MAX_SIDE, 2));
      default: return SIDE_W'($urandom_range(40, 2));
    endcase
  endfunction

  // Element index for the current grid: mostly in range, with grid edges,
  // indexes past the end and fully random words mixed in.
  function automatic logic [IDX_W-1:0] pick_index();
    longint unsigned nx, ny, cells;
    int roll;
    nx    = usable_side(mirror_columns);
    ny    = usable_side(mirror_rows);
    cells = nx * ny;
    roll  = $urandom_range(99);
    if (roll < 8) begin
      return IDX_W'($urandom);
    end else if (roll < 16 && cells < (longint'(1) << IDX_W)) begin
      return IDX_W'($urandom_range((1 << IDX_W) - 1, cells));
    end else if (roll < 26) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return IDX_W'(cells - 1);
        2:       return IDX_W'(nx - 1);
        default: return IDX_W'(cells - nx);
      endcase
    end
    return IDX_W'($urandom_range(cells - 1, 0));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Out of reset the grid is a single element in plain numbering.
  task automatic test_reset_grid();
    send_element('0);
    send_element(IDX_W'(1));
    send_element('1);
    drain_results();
  endtask

  // A small 5 by 3 grid: first element, right edge, top row, last element,
  // the first index past the end and an all-ones index, in both numberings.
  task automatic test_small_grid_edges();
    logic [IDX_W-1:0] probes [6];
    probes = '{IDX_W'(0), IDX_W'(4), IDX_W'(10), IDX_W'(14), IDX_W'(15), '1};
    for (int mode = 0; mode < 2; mode++) begin
      set_grid(SIDE_W'(5), SIDE_W'(3), SIDE_W'(mode));
      foreach (probes[k]) send_element(probes[k]);
      drain_results();
    end
  endtask

  // The largest grid fills the whole index space; its far corner gives the
  // widest node numbers.
  task automatic test_largest_grid();
    for (int mode = 0; mode < 2; mode++) begin
      set_grid(SIDE_W'(MAX_SIDE), SIDE_W'(MAX_SIDE), SIDE_W'(mode));
      send_element('0);
      send_element(IDX_W'(MAX_SIDE - 1));
      send_element(IDX_W'((MAX_SIDE - 1) * MAX_SIDE));
      send_element('1);
      drain_results();
    end
  endtask

  // Zero columns act as one, an oversized row count as the limit, and a write
  // to the unmapped register index changes nothing.
  task automatic test_side_clamp_and_unmapped();
    set_grid('0, '1, '0);
    send_element(IDX_W'(MAX_SIDE - 1));
    send_element(IDX_W'(MAX_SIDE));
    drain_results();
    write_register(CFG_UNMAPPED, '1);
    send_element(IDX_W'(MAX_SIDE - 1));
    drain_results();
  endtask

  // Random grids, random mode bits and random indexes, with idling on both
  // sides.
  task automatic test_random_grids();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_grid(pick_side(), pick_side(), SIDE_W'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) send_element(pick_index());
      drain_results();
    end
  endtask

  // A long stretch with no idling at all on either side.
  task automatic test_full_rate_stream();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_grid(SIDE_W'($urandom_range(MAX_SIDE, 1)), SIDE_W'($urandom_range(64, 1)),
             SIDE_W'($urandom));
    for (int n = 0; n < 100; n++) send_element(pick_index());
    drain_results();
    send_idle_pct = 35;
    recv_idle_pct = 35;
  endtask

  // The receiver holds off long enough for the pipeline to fill while the
  // sender keeps offering, so the unit has to stall its input.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    set_grid(SIDE_W'($urandom_range(200, 2)), SIDE_W'($urandom_range(200, 2)), '1);
    stall_hold_left = 250;
    for (int n = 0; n < 80; n++) send_element(pick_index());
    drain_results();
    send_idle_pct = 35;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    cfg_write_en     = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_element_index = '0;
    out_stall        = 1'b0;
    mirror_columns   = SIDE_W'(1);
    mirror_rows      = SIDE_W'(1);
    mirror_periodic  = 1'b0;
    mismatch_count   = 0;
    cycle_count      = 0;
    send_idle_pct    = 35;
    recv_idle_pct    = 35;
    stall_hold_left  = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_grid();
    test_small_grid_edges();
    test_largest_grid();
    test_side_clamp_and_unmapped();
    test_random_grids();
    test_full_rate_stream();
    test_output_backpressure();

    // Everything is back; give the unit time to show any stray result.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_connectivity.size() == 0) begin
      $display("tb_quad8_element_connectivity_unit: PASS");
    end else begin
      $display("tb_quad8_element_connectivity_unit: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/qec_pkg.sv
rtl/core/qec_div_cell.sv
rtl/core/qec_node_calc.sv
rtl/core/quad8_element_connectivity_unit.sv
verif/tb_quad8_element_connectivity_unit.sv
